FILE: hw/rtl/laplacian_sharpen_3x3_core_assert.svh
`ifndef LAPLACIAN_SHARPEN_3X3_CORE_ASSERT_SVH
`define LAPLACIAN_SHARPEN_3X3_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define LSH_ASSERT_HOLDS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define LSH_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/lsh_pkg.sv
package lsh_pkg;

    localparam int PIX_W      = 8;
    localparam int FW_W       = 12;
    localparam int FH_W       = 16;
    localparam int GAIN_W     = 10;
    localparam int ROW_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_AW    = 3;
    localparam int PEND_W     = 4;

    localparam int FRAC_BITS  = 8;
    localparam int COEF_W     = 12;
    localparam int PROD_W     = 20;
    localparam int NSUM_W     = 11;
    localparam int ACC_W      = 22;
    localparam int K4_Q8      = 4 * 256;
    localparam int K8_Q8      = 8 * 256;
    localparam int ROUND_HALF = 128;
    localparam int PIX_MAX    = 255;

    localparam int TAPS   = 9;
    localparam int TAP_UL = 0;
    localparam int TAP_UP = 1;
    localparam int TAP_UR = 2;
    localparam int TAP_LF = 3;
    localparam int TAP_C  = 4;
    localparam int TAP_RT = 5;
    localparam int TAP_DL = 6;
    localparam int TAP_DN = 7;
    localparam int TAP_DR = 8;

    localparam logic [FW_W-1:0]   FW_RESET   = 12'd640;
    localparam logic [FH_W-1:0]   FH_RESET   = 16'd480;
    localparam logic              DIAG_RESET = 1'b0;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_USE_DIAG     = 2'd2,
        REG_GAIN         = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic has_res;
        logic last;
        logic up_ok;
        logic dn_ok;
        logic lf_ok;
        logic rt_ok;
    } lsh_ctrl_t;

endpackage

FILE: hw/rtl/lsh_linebuf.sv
module lsh_linebuf #(
    parameter int MAX_WIDTH = 2048,
    parameter int CHANNELS  = 3
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]        rd_addr,
    input  logic [lsh_pkg::PIX_W*CHANNELS-1:0]  wr_pix,
    output logic                                clear_busy,
    output logic [lsh_pkg::PIX_W*CHANNELS-1:0]  win [lsh_pkg::TAPS]
);
    import lsh_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PW = PIX_W * CHANNELS;

    logic [2*PW-1:0] mem [MAX_WIDTH];
    logic [2*PW-1:0] rd_reg;
    logic [2*PW-1:0] fwd_data_reg;
    logic            fwd_reg;
    logic            s1_valid_reg;
    logic [CW-1:0]   s1_addr_reg;
    logic [PW-1:0]   s1_pix_reg;
    logic [CW-1:0]   clr_addr_reg;
    logic            clear_busy_reg;
    logic [PW-1:0]   win_reg [TAPS];

    logic [2*PW-1:0] line_word;
    logic [PW-1:0]   up_pix;
    logic [PW-1:0]   lo_pix;
    logic [2*PW-1:0] wr_word;

    // The item right behind another at the same column reads a stale word.
    assign line_word = fwd_reg ? fwd_data_reg : rd_reg;
    assign up_pix    = line_word[2*PW-1:PW];
    assign lo_pix    = line_word[PW-1:0];
    assign wr_word   = {lo_pix, s1_pix_reg};

    always_ff @(posedge aclk) begin
        if (clear_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (s1_valid_reg) begin
            mem[s1_addr_reg] <= wr_word;
        end
        if (rd_en) begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            s1_addr_reg <= rd_addr;
            s1_pix_reg  <= wr_pix;
        end
        if (s1_valid_reg) begin
            fwd_data_reg <= wr_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            fwd_reg        <= 1'b0;
            clear_busy_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else begin
            s1_valid_reg <= rd_en;
            fwd_reg      <= rd_en && s1_valid_reg && (s1_addr_reg == rd_addr);
            if (clear_busy_reg) begin
                if (clr_addr_reg == CW'(MAX_WIDTH - 1)) begin
                    clear_busy_reg <= 1'b0;
                end else begin
                    clr_addr_reg <= clr_addr_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TAPS; i++) begin
                win_reg[i] <= '0;
            end
        end else if (s1_valid_reg) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r*3]     <= win_reg[r*3 + 1];
                win_reg[r*3 + 1] <= win_reg[r*3 + 2];
            end
            win_reg[TAP_UR] <= up_pix;
            win_reg[TAP_RT] <= lo_pix;
            win_reg[TAP_DR] <= s1_pix_reg;
        end
    end

    assign win        = win_reg;
    assign clear_busy = clear_busy_reg;

endmodule

FILE: hw/rtl/lsh_lane.sv
module lsh_lane (
    input  logic                        aclk,
    input  logic [lsh_pkg::PIX_W-1:0]   taps [lsh_pkg::TAPS],
    input  lsh_pkg::lsh_ctrl_t          ctrl,
    input  logic                        diag,
    input  logic [lsh_pkg::GAIN_W-1:0]  gain,
    output logic [lsh_pkg::PIX_W-1:0]   result
);
    import lsh_pkg::*;

    logic [NSUM_W-1:0]       nsum;
    logic [COEF_W-1:0]       coef;
    logic [PROD_W-1:0]       prod;
    logic [NSUM_W-1:0]       nsum_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] scaled;
    logic [PIX_W-1:0]        result_next;
    logic [PIX_W-1:0]        result_reg;

    always_comb begin
        nsum = '0;
        if (ctrl.up_ok) nsum = nsum + NSUM_W'(taps[TAP_UP]);
        if (ctrl.dn_ok) nsum = nsum + NSUM_W'(taps[TAP_DN]);
        if (ctrl.lf_ok) nsum = nsum + NSUM_W'(taps[TAP_LF]);
        if (ctrl.rt_ok) nsum = nsum + NSUM_W'(taps[TAP_RT]);
        if (diag && ctrl.up_ok && ctrl.lf_ok) nsum = nsum + NSUM_W'(taps[TAP_UL]);
        if (diag && ctrl.up_ok && ctrl.rt_ok) nsum = nsum + NSUM_W'(taps[TAP_UR]);
        if (diag && ctrl.dn_ok && ctrl.lf_ok) nsum = nsum + NSUM_W'(taps[TAP_DL]);
        if (diag && ctrl.dn_ok && ctrl.rt_ok) nsum = nsum + NSUM_W'(taps[TAP_DR]);
    end

    assign coef = COEF_W'(gain) + (diag ? COEF_W'(K8_Q8) : COEF_W'(K4_Q8));
    assign prod = PROD_W'(coef) * PROD_W'(taps[TAP_C]);

    always_ff @(posedge aclk) begin
        nsum_reg <= nsum;
        prod_reg <= prod;
    end

    // Arithmetic shift floors, so adding one half first rounds half up.
    always_comb begin
        acc    = $signed({2'b00, prod_reg}) - $signed({3'b000, nsum_reg, 8'h00});
        scaled = (acc + ACC_W'(ROUND_HALF)) >>> FRAC_BITS;
        if (scaled < 0) begin
            result_next = '0;
        end else if (scaled > ACC_W'(PIX_MAX)) begin
            result_next = PIX_W'(PIX_MAX);
        end else begin
            result_next = scaled[PIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

FILE: hw/rtl/lsh_outq.sv
module lsh_outq #(
    parameter int CHANNELS = 3
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                push,
    input  logic [lsh_pkg::PIX_W-1:0]           lane_res [CHANNELS],
    input  logic                                push_last,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lsh_pkg::PIX_W*CHANNELS-1:0]  m_tdata,
    output logic                                m_tlast
);
    import lsh_pkg::*;

    localparam int PW = PIX_W * CHANNELS;

    logic [PW:0]        q_reg [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] wr_ptr_reg;
    logic [OUTQ_AW-1:0] rd_ptr_reg;
    logic [OUTQ_AW:0]   count_reg;
    logic [OUTQ_AW:0]   count_next;
    logic [PW-1:0]      merged;
    logic               pop;

    always_comb begin
        merged = '0;
        for (int k = 0; k < CHANNELS; k++) begin
            merged[k*PIX_W +: PIX_W] = lane_res[k];
        end
    end

    assign pop        = m_tvalid && m_tready;
    assign count_next = count_reg + (OUTQ_AW+1)'(push) - (OUTQ_AW+1)'(pop);

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= {push_last, merged};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + OUTQ_AW'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + OUTQ_AW'(1);
            count_reg <= count_next;
        end
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = q_reg[rd_ptr_reg][PW-1:0];
    assign m_tlast  = q_reg[rd_ptr_reg][PW];

endmodule

FILE: hw/rtl/laplacian_sharpen_3x3_core.sv
// Sharpens a raster-order pixel stream with a 3x3 Laplacian kernel, one lane per channel.
// Pixels enter on the s_ channel, one item per pixel, with s_tuser set on the W+1 zero
// flush items that the host sends after each frame. Results leave on the m_ channel in
// raster order; m_tlast marks the final pixel of the frame. Registers are written through
// the cfg_ channel, which is always ready; the host must write them only while no item is
// in flight, which the block itself does not enforce. Throughput is one item per clock
// while s_tready is high. The result for a pixel is completed by the item accepted W+1
// items later and passes through the line store read, the window and the lane arithmetic
// registers and the output queue before it appears on m_tvalid. The two line stores share
// one memory that is read and written once per clock. An output queue of eight items
// decouples the two sides: s_tready stays high while m_tready is low until the queue and
// the pipeline together hold eight items. After reset the line memory is cleared one
// column per clock; s_tready stays low during that time, and the registers return to a 640
// by 480 frame, the four-neighbour kernel and unity gain.
`include "laplacian_sharpen_3x3_core_assert.svh"

module laplacian_sharpen_3x3_core #(
    parameter int MAX_WIDTH = 2048,
    parameter int CHANNELS  = 3
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // chan_a_in, chan_b_in, chan_c_in from the lowest bit up
    input  logic [lsh_pkg::PIX_W*CHANNELS-1:0]   s_tdata,
    // is_flush
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // chan_a_out, chan_b_out, chan_c_out from the lowest bit up
    output logic [lsh_pkg::PIX_W*CHANNELS-1:0]   m_tdata,
    output logic                                 m_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lsh_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lsh_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import lsh_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > FW_W) ? CW + 1 : FW_W;
    localparam int PW = PIX_W * CHANNELS;
    localparam logic [ROW_W:0] RO_ONE = (ROW_W+1)'(1);
    localparam logic [ROW_W:0] RO_TWO = (ROW_W+1)'(2);

    logic [FW_W-1:0]   fw_reg;
    logic [FH_W-1:0]   fh_reg;
    logic              diag_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [CW-1:0]     col_reg;
    logic [CW-1:0]     col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [PEND_W-1:0] pending_reg;
    logic [PEND_W-1:0] pending_next;

    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    lsh_ctrl_t         ctrl1_reg, ctrl2_reg, ctrl3_reg, ctrl4_reg;
    lsh_ctrl_t         ctrl_acc;

    logic              s_acc;
    logic              clear_busy;
    logic [WW-1:0]     w_raw;
    logic [WW-1:0]     w_eff;
    logic [WW-1:0]     wm1;
    logic [WW-1:0]     col_ext;
    logic [WW-1:0]     co;
    logic [FH_W-1:0]   h_eff;
    logic [ROW_W-1:0]  h_ext;
    logic [ROW_W-1:0]  hm1;
    logic signed [ROW_W:0] ro;
    logic [ROW_W-1:0]  ro_mag;
    logic              col_wrap;
    logic [PW-1:0]     pix;
    logic              drop;

    logic [PW-1:0]     win [TAPS];
    logic [PIX_W-1:0]  lane_taps [CHANNELS][TAPS];
    logic [PIX_W-1:0]  lane_res [CHANNELS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg   <= FW_RESET;
            fh_reg   <= FH_RESET;
            diag_reg <= DIAG_RESET;
            gain_reg <= GAIN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH: begin
                    fw_reg <= cfg_data[FW_W-1:0];
                end
                REG_FRAME_HEIGHT: begin
                    fh_reg <= cfg_data[FH_W-1:0];
                end
                REG_USE_DIAG: begin
                    diag_reg <= cfg_data[0];
                end
                REG_GAIN: begin
                    gain_reg <= cfg_data[GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign s_tready = !clear_busy && (pending_reg < PEND_W'(OUTQ_DEPTH));
    assign s_acc    = s_tvalid && s_tready;
    assign pix      = s_tuser ? '0 : s_tdata;

    // Position of the window centre that this item completes, and the position of the next item.
    always_comb begin
        w_raw    = (fw_reg == '0) ? WW'(1) : WW'(fw_reg);
        w_eff    = (w_raw > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_raw;
        wm1      = w_eff - WW'(1);
        col_ext  = WW'(col_reg);
        h_eff    = (fh_reg == '0) ? FH_W'(1) : fh_reg;
        h_ext    = ROW_W'(h_eff);
        hm1      = h_ext - ROW_W'(1);
        ro       = $signed({1'b0, row_reg}) - $signed((col_reg == '0) ? RO_TWO : RO_ONE);
        ro_mag   = ro[ROW_W-1:0];
        co       = (col_reg == '0) ? wm1 : col_ext - WW'(1);
        col_wrap = (col_ext + WW'(1)) >= w_eff;

        ctrl_acc.has_res = !ro[ROW_W] && (ro_mag < h_ext) && (co < w_eff);
        ctrl_acc.last    = (ro_mag == hm1) && (co == wm1);
        ctrl_acc.up_ok   = (ro_mag != '0);
        ctrl_acc.dn_ok   = (ro_mag < hm1);
        ctrl_acc.lf_ok   = (co != '0);
        ctrl_acc.rt_ok   = (co < wm1);

        if (ctrl_acc.has_res && ctrl_acc.last) begin
            col_next = '0;
            row_next = '0;
        end else if (col_wrap) begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end else begin
            col_next = col_reg + CW'(1);
            row_next = row_reg;
        end
    end

    assign drop         = v4_reg && !ctrl4_reg.has_res;
    assign pending_next = pending_reg + PEND_W'(s_acc) - PEND_W'(m_tvalid && m_tready)
                          - PEND_W'(drop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            pending_reg <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
        end else begin
            if (s_acc) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            pending_reg <= pending_next;
            v1_reg      <= s_acc;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        ctrl1_reg <= ctrl_acc;
        ctrl2_reg <= ctrl1_reg;
        ctrl3_reg <= ctrl2_reg;
        ctrl4_reg <= ctrl3_reg;
    end

    lsh_linebuf #(
        .MAX_WIDTH (MAX_WIDTH),
        .CHANNELS  (CHANNELS)
    ) u_linebuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_en      (s_acc),
        .rd_addr    (col_reg),
        .wr_pix     (pix),
        .clear_busy (clear_busy),
        .win        (win)
    );

    for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
        for (genvar t = 0; t < TAPS; t++) begin : g_tap
            assign lane_taps[k][t] = win[t][k*PIX_W +: PIX_W];
        end

        lsh_lane u_lane (
            .aclk   (aclk),
            .taps   (lane_taps[k]),
            .ctrl   (ctrl2_reg),
            .diag   (diag_reg),
            .gain   (gain_reg),
            .result (lane_res[k])
        );
    end

    lsh_outq #(
        .CHANNELS (CHANNELS)
    ) u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (v4_reg && ctrl4_reg.has_res),
        .lane_res  (lane_res),
        .push_last (ctrl4_reg.last),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    `LSH_ASSERT_HOLDS(a_pending_bound, aclk, aresetn, pending_reg <= PEND_W'(OUTQ_DEPTH), "pending count beyond queue depth")
    `LSH_ASSERT_HOLDS(a_clear_empty, aclk, aresetn, !clear_busy || (pending_reg == '0 && !v1_reg), "item in flight during line clear")
    `LSH_ASSERT_HOLDS(a_valid_pending, aclk, aresetn, !m_tvalid || pending_reg != '0, "result shown with nothing pending")
    `LSH_ASSERT_NEXT(a_frame_restart, aclk, aresetn, s_acc && ctrl_acc.has_res && ctrl_acc.last, col_reg == '0 && row_reg == '0, "position not reset after frame end")

endmodule

FILE: test/lsh_checker.sv
`timescale 1ns / 1ps

module lsh_checker #(
    parameter int MAX_WIDTH = 2048,
    parameter int CHANNELS  = 3
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    // chan_a_in, chan_b_in, chan_c_in from the lowest bit up
    input  logic [lsh_pkg::PIX_W*CHANNELS-1:0]   s_tdata,
    // is_flush
    input  logic                                 s_tuser,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    // chan_a_out, chan_b_out, chan_c_out from the lowest bit up
    input  logic [lsh_pkg::PIX_W*CHANNELS-1:0]   m_tdata,
    input  logic                                 m_tlast,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [lsh_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lsh_pkg::CFG_DATA_W-1:0]       cfg_data,
    output int                                   results_owed,
    output int                                   mismatches
);
    import lsh_pkg::*;

    localparam int PX_W = PIX_W * CHANNELS;

    typedef struct packed {
        logic [PX_W-1:0] pix;
        logic            last;
    } sharp_px_t;

    logic [PX_W-1:0]   line_upper [MAX_WIDTH];
    logic [PX_W-1:0]   line_lower [MAX_WIDTH];
    logic [PX_W-1:0]   win [TAPS];
    int                col_pos;
    int                row_pos;
    logic [FW_W-1:0]   width_r;
    logic [FH_W-1:0]   height_r;
    logic              diag_r;
    logic [GAIN_W-1:0] gain_r;
    sharp_px_t         sharpened_q [$];

    function automatic logic [PIX_W-1:0] sharpen_sample(int centre, int nsum);
        longint acc;
        longint rounded;
        acc = (longint'(gain_r) + (diag_r ? K8_Q8 : K4_Q8)) * centre - 256 * longint'(nsum);
        rounded = (acc + ROUND_HALF) >>> FRAC_BITS;
        if (rounded < 0) begin
            return '0;
        end else if (rounded > PIX_MAX) begin
            return PIX_W'(PIX_MAX);
        end
        return rounded[PIX_W-1:0];
    endfunction

    task automatic sharpen_next_pixel(input logic [PX_W-1:0] px, input logic flush);
        int              w;
        int              h;
        int              ci;
        int              ri;
        int              idx;
        int              ro;
        int              co;
        int              nsum;
        logic [PX_W-1:0] v;
        logic [PX_W-1:0] u;
        logic [PX_W-1:0] l;
        bit              row_ok [3];
        bit              col_ok [3];
        sharp_px_t       e;
        w = (width_r == 0) ? 1 : int'(width_r);
        if (w > MAX_WIDTH) begin
            w = MAX_WIDTH;
        end
        h = (height_r == 0) ? 1 : int'(height_r);
        v = flush ? '0 : px;
        ci = col_pos;
        ri = row_pos;

        idx = (ci < MAX_WIDTH) ? ci : MAX_WIDTH - 1;
        u = line_upper[idx];
        l = line_lower[idx];
        line_upper[idx] = l;
        line_lower[idx] = v;

        for (int r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        win[2] = u;
        win[5] = l;
        win[8] = v;

        if (ci == 0) begin
            ro = ri - 2;
            co = w - 1;
        end else begin
            ro = ri - 1;
            co = ci - 1;
        end

        if (ci + 1 >= w) begin
            col_pos = 0;
            row_pos = (ri + 1) & 32'h1FFFF;
        end else begin
            col_pos = ci + 1;
        end

        if (ro < 0 || ro >= h || co >= w) begin
            return;
        end

        row_ok[0] = ro > 0;
        row_ok[1] = 1'b1;
        row_ok[2] = ro < h - 1;
        col_ok[0] = co > 0;
        col_ok[1] = 1'b1;
        col_ok[2] = co < w - 1;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            nsum = 0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    if (!(r == 1 && c == 1) && (diag_r || r == 1 || c == 1) &&
                        row_ok[r] && col_ok[c]) begin
                        nsum += int'(win[r*3+c][PIX_W*ch +: PIX_W]);
                    end
                end
            end
            e.pix[PIX_W*ch +: PIX_W] =
                sharpen_sample(int'(win[TAP_C][PIX_W*ch +: PIX_W]), nsum);
        end
        e.last = 1'b0;
        if (ro == h - 1 && co == w - 1) begin
            e.last  = 1'b1;
            col_pos = 0;
            row_pos = 0;
        end
        sharpened_q.push_back(e);
    endtask

    task automatic compare_sharpened();
        sharp_px_t e;
        bit        bad;
        if (sharpened_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Unexpected output item: data %h last %b", m_tdata, m_tlast);
            end
            return;
        end
        e = sharpened_q.pop_front();
        bad = m_tlast !== e.last;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            if (m_tdata[PIX_W*ch +: PIX_W] !== e.pix[PIX_W*ch +: PIX_W]) begin
                bad = 1'b1;
            end
        end
        if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Output mismatch: expected data %h last %b, got data %h last %b",
                         e.pix, e.last, m_tdata, m_tlast);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_WIDTH; i++) begin
                line_upper[i] = '0;
                line_lower[i] = '0;
            end
            for (int i = 0; i < TAPS; i++) begin
                win[i] = '0;
            end
            col_pos  = 0;
            row_pos  = 0;
            width_r  = FW_RESET;
            height_r = FH_RESET;
            diag_r   = DIAG_RESET;
            gain_r   = GAIN_RESET;
            sharpened_q.delete();
            mismatches = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FRAME_WIDTH: begin
                        width_r = cfg_data[FW_W-1:0];
                    end
                    REG_FRAME_HEIGHT: begin
                        height_r = cfg_data[FH_W-1:0];
                    end
                    REG_USE_DIAG: begin
                        diag_r = cfg_data[0];
                    end
                    REG_GAIN: begin
                        gain_r = cfg_data[GAIN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                sharpen_next_pixel(s_tdata, s_tuser);
            end
            if (m_tvalid && m_tready) begin
                compare_sharpened();
            end
        end
        results_owed = sharpened_q.size();
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import lsh_pkg::*;

    localparam int MAX_WIDTH     = 2048;
    localparam int CHANNELS      = 3;
    localparam int PX_W          = PIX_W * CHANNELS;
    localparam int STALL_LIMIT   = 10000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS  = 820;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [PX_W-1:0]       s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [PX_W-1:0]       m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int results_owed;
    int mismatches;
    int idle_cycles = 0;
    int items_sent = 0;
    bit no_gaps = 1'b0;

    laplacian_sharpen_3x3_core #(
        .MAX_WIDTH(MAX_WIDTH),
        .CHANNELS (CHANNELS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    lsh_checker #(
        .MAX_WIDTH(MAX_WIDTH),
        .CHANNELS (CHANNELS)
    ) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .results_owed(results_owed),
        .mismatches  (mismatches)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    function automatic logic [PIX_W-1:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(0, PIX_MAX));
        endcase
    endfunction

    function automatic logic [PX_W-1:0] rand_pixel();
        logic [PX_W-1:0] px;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            px[PIX_W*ch +: PIX_W] = rand_sample();
        end
        return px;
    endfunction

    function automatic int eff_width(int w);
        if (w == 0) begin
            return 1;
        end
        return (w > MAX_WIDTH) ? MAX_WIDTH : w;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input logic [PX_W-1:0] px, input logic flush);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tuser  <= flush;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // Bits above each register's width carry random junk.
    task automatic configure(input int w, input int h, input bit diag, input int gain);
        logic [CFG_DATA_W-1:0] val;
        val = CFG_DATA_W'($urandom);
        val[FW_W-1:0] = w[FW_W-1:0];
        write_reg(REG_FRAME_WIDTH, val);
        write_reg(REG_FRAME_HEIGHT, h[FH_W-1:0]);
        val = CFG_DATA_W'($urandom);
        val[0] = diag;
        write_reg(REG_USE_DIAG, val);
        val = CFG_DATA_W'($urandom);
        val[GAIN_W-1:0] = gain[GAIN_W-1:0];
        write_reg(REG_GAIN, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (results_owed != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Some pixels inside the frame are flagged as flush, and some trailing items
    // carry live data instead of the flush flag.
    task automatic run_frame(input int w, input int h);
        int we;
        int he;
        we = eff_width(w);
        he = (h == 0) ? 1 : h;
        for (int i = 0; i < we * he; i++) begin
            send_item(rand_pixel(), $urandom_range(0, 15) == 0);
        end
        for (int i = 0; i <= we; i++) begin
            send_item(rand_pixel(), $urandom_range(0, 4) != 0);
        end
        wait_drained();
    endtask

    initial begin
        int start;
        int w;
        int h;
        int gain;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data  = '0;
        aresetn   = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Zero width and height act as a single pixel frame.
        configure(0, 0, 1'b0, 1023);
        send_item({8'd128, 8'd0, 8'd255}, 1'b0);
        send_item('1, 1'b1);
        send_item('1, 1'b1);
        wait_drained();

        // Zero gain with the diagonal kernel drives both saturation limits.
        configure(3, 2, 1'b1, 0);
        send_item('1, 1'b0);
        send_item('0, 1'b0);
        send_item(24'hFF00FF, 1'b0);
        send_item(24'h00FF00, 1'b0);
        send_item('1, 1'b0);
        send_item(24'h80017F, 1'b0);
        repeat (4) send_item('1, 1'b1);
        wait_drained();

        // Width and height shrink in the middle of a frame; the column count
        // beyond the new width wraps without a result.
        configure(4095, 65535, 1'b0, 300);
        repeat (5) send_item(rand_pixel(), 1'b0);
        wait_drained();
        configure(3, 2, 1'b1, 512);
        repeat (8) send_item(rand_pixel(), 1'b0);
        wait_drained();

        // One frame with rows much wider than those of the random frames.
        configure(100, 2, 1'($urandom_range(0, 1)), $urandom_range(0, 1023));
        run_frame(100, 2);

        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: w = 0;
                1: w = $urandom_range(13, 48);
                default: w = $urandom_range(1, 12);
            endcase
            h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            case ($urandom_range(0, 7))
                0: gain = 0;
                1: gain = 1023;
                2: gain = 256;
                default: gain = $urandom_range(0, 1023);
            endcase
            no_gaps = $urandom_range(0, 3) == 0;
            configure(w, h, 1'($urandom_range(0, 1)), gain);
            run_frame(w, h);
        end
        no_gaps = 1'b0;
        wait_drained();
        repeat (8) @(negedge aclk);

        if (mismatches == 0 && results_owed == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
